[hw/rtl/assert_macros.svh]
// Assertion macros shared by the tracker and steering RTL files. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: always");

// Whenever the trigger holds, the condition holds in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("assertion failed: implication");

// Whenever the trigger holds, the condition holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("assertion failed: next cycle");

`else

`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLIES(label, clk, rst, trig, cond)
`define ASSERT_NEXT(label, clk, rst, trig, cond)

`endif

`endif

[hw/rtl/lbts_pkg.sv]
package lbts_pkg;

   localparam int MAX_WIDTH = 1024;

   localparam int AREA_W    = 18;
   localparam int POS_W     = 14;
   localparam int FW_W      = 11;
   localparam int GAIN_W    = 16;
   localparam int BASE_W    = 16;
   localparam int ERR_W     = 16;
   localparam int SPEED_W   = 24;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 18;

   // Midline in 1/16 pixel is the clamped width times eight.
   localparam int MID_W  = $clog2(MAX_WIDTH * 8 + 1);
   localparam int DIST_W = (2 * MID_W > 2 * POS_W + 1) ? 2 * MID_W : 2 * POS_W + 1;
   localparam int ERRX_W = ((MID_W + 1 > POS_W + 1) ? MID_W + 1 : POS_W + 1) + 1;

   localparam int PROD_W      = ERR_W + GAIN_W + 1;
   localparam int ROUND_SHIFT = 9;
   localparam int ROUND_HALF  = 256;
   localparam int Q_W         = PROD_W + 1 - ROUND_SHIFT;
   localparam int BASE_SHIFT  = 4;
   localparam int BASEX_W     = BASE_W + BASE_SHIFT;
   localparam int SPDX_W      = ((Q_W > BASEX_W) ? Q_W : BASEX_W) + 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MIN_AREA,
      REG_LEFT_GATE,
      REG_RIGHT_GATE,
      REG_FRAME_WIDTH,
      REG_STEER_GAIN,
      REG_BASE_SPEED,
      REG_DRIVE_ENABLE
   } csr_index_type;

   typedef struct packed {
      logic [AREA_W-1:0]        min_area;
      logic [POS_W-1:0]         left_gate;
      logic [POS_W-1:0]         right_gate;
      logic [FW_W-1:0]          frame_width;
      logic [GAIN_W-1:0]        steer_gain;
      logic signed [BASE_W-1:0] base_speed;
      logic                     drive_enable;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      min_area:     18'd300,
      left_gate:    14'd1280,
      right_gate:   14'd1440,
      frame_width:  11'd640,
      steer_gain:   16'd36,
      base_speed:   16'sd100,
      drive_enable: 1'b0
   };

   typedef struct packed {
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
   } xy_type;

   localparam xy_type TRACK_LEFT_RESET  = '{x: 14'd2400, y: 14'd720};
   localparam xy_type TRACK_RIGHT_RESET = '{x: 14'd8640, y: 14'd720};

   typedef struct packed {
      logic              has_blob;
      logic [AREA_W-1:0] blob_area;
      logic [POS_W-1:0]  center_x;
      logic [POS_W-1:0]  center_y;
      logic              frame_end;
   } req_type;

   // Frame summary handed from the tracker to the steering pipeline.
   typedef struct packed {
      logic [POS_W-1:0] left_x;
      logic [POS_W-1:0] right_x;
      logic             left_found;
      logic             right_found;
   } sum_type;

   typedef struct packed {
      logic signed [SPEED_W-1:0] left_speed;
      logic signed [SPEED_W-1:0] right_speed;
      logic signed [ERR_W-1:0]   steer_error;
      logic [POS_W-1:0]          left_pos;
      logic [POS_W-1:0]          right_pos;
      logic                      left_found;
      logic                      right_found;
   } rsp_type;

   function automatic logic [MID_W-1:0] mid_of(input logic [FW_W-1:0] fw);
      logic [MID_W-1:0] mid;
      if (32'(fw) > MAX_WIDTH) begin
         mid = MID_W'(MAX_WIDTH * 8);
      end else begin
         mid = MID_W'({fw, 3'b000});
      end
      return mid;
   endfunction

endpackage

[hw/rtl/lbts_tracker.sv]
`include "assert_macros.svh"

module lbts_tracker (
   input  logic             clock,
   input  logic             reset,
   input  lbts_pkg::cfg_type cfg,
   input  logic             req_valid,
   output logic             req_stall,
   input  lbts_pkg::req_type req,
   output logic             sum_valid,
   input  logic             sum_ready,
   output lbts_pkg::sum_type sum
);

   logic                            s0_valid_ff, s0_valid_in;
   lbts_pkg::req_type               s0_ff, s0_in;
   logic                            left_found_ff, left_found_in;
   logic                            right_found_ff, right_found_in;
   logic [lbts_pkg::DIST_W-1:0]     best_left_ff, best_left_in;
   logic [lbts_pkg::DIST_W-1:0]     best_right_ff, best_right_in;
   lbts_pkg::xy_type                cand_left_ff, cand_left_in;
   lbts_pkg::xy_type                cand_right_ff, cand_right_in;
   lbts_pkg::xy_type                track_left_ff, track_left_in;
   lbts_pkg::xy_type                track_right_ff, track_right_in;

   logic                            s0_go;
   logic [lbts_pkg::MID_W-1:0]      mid;
   logic [2*lbts_pkg::MID_W-1:0]    mid_sq;
   logic [2*lbts_pkg::POS_W-1:0]    left_gate_sq, right_gate_sq;
   logic [lbts_pkg::POS_W-1:0]      dlx, dly, drx, dry;
   logic [2*lbts_pkg::POS_W-1:0]    sq_lx, sq_ly, sq_rx, sq_ry;
   logic [lbts_pkg::DIST_W-1:0]     dist_left, dist_right;
   logic [lbts_pkg::DIST_W-1:0]     bound_left, bound_right;
   logic                            blob_ok, on_left;
   logic                            hit_left, hit_right;
   logic                            left_found_nx, right_found_nx;
   lbts_pkg::xy_type                cand_left_nx, cand_right_nx;

   assign s0_go     = s0_valid_ff && (!s0_ff.frame_end || sum_ready);
   assign req_stall = s0_valid_ff && !s0_go;

   assign s0_valid_in = req_stall ? s0_valid_ff : req_valid;
   assign s0_in       = (req_valid && !req_stall) ? req : s0_ff;

   // Both sides are scored in parallel; the side test only picks the winner.
   assign mid           = lbts_pkg::mid_of(cfg.frame_width);
   assign mid_sq        = mid * mid;
   assign left_gate_sq  = cfg.left_gate * cfg.left_gate;
   assign right_gate_sq = cfg.right_gate * cfg.right_gate;

   assign dlx = (s0_ff.center_x >= track_left_ff.x) ? s0_ff.center_x - track_left_ff.x
                                                    : track_left_ff.x - s0_ff.center_x;
   assign dly = (s0_ff.center_y >= track_left_ff.y) ? s0_ff.center_y - track_left_ff.y
                                                    : track_left_ff.y - s0_ff.center_y;
   assign drx = (s0_ff.center_x >= track_right_ff.x) ? s0_ff.center_x - track_right_ff.x
                                                     : track_right_ff.x - s0_ff.center_x;
   assign dry = (s0_ff.center_y >= track_right_ff.y) ? s0_ff.center_y - track_right_ff.y
                                                     : track_right_ff.y - s0_ff.center_y;

   assign sq_lx = dlx * dlx;
   assign sq_ly = dly * dly;
   assign sq_rx = drx * drx;
   assign sq_ry = dry * dry;

   assign dist_left  = lbts_pkg::DIST_W'(sq_lx) + lbts_pkg::DIST_W'(sq_ly);
   assign dist_right = lbts_pkg::DIST_W'(sq_rx) + lbts_pkg::DIST_W'(sq_ry);

   // Until a side has a candidate, its bound is the midline squared.
   assign bound_left  = left_found_ff  ? best_left_ff  : lbts_pkg::DIST_W'(mid_sq);
   assign bound_right = right_found_ff ? best_right_ff : lbts_pkg::DIST_W'(mid_sq);

   assign blob_ok = s0_ff.has_blob && (s0_ff.blob_area >= cfg.min_area);
   assign on_left = lbts_pkg::DIST_W'(s0_ff.center_x) < lbts_pkg::DIST_W'(mid);

   assign hit_left  = blob_ok && on_left && (dist_left < bound_left) &&
                      (dist_left <= lbts_pkg::DIST_W'(left_gate_sq));
   assign hit_right = blob_ok && !on_left && (dist_right < bound_right) &&
                      (dist_right <= lbts_pkg::DIST_W'(right_gate_sq));

   assign left_found_nx  = left_found_ff || hit_left;
   assign right_found_nx = right_found_ff || hit_right;
   assign cand_left_nx   = hit_left
                           ? lbts_pkg::xy_type'{x: s0_ff.center_x, y: s0_ff.center_y}
                           : cand_left_ff;
   assign cand_right_nx  = hit_right
                           ? lbts_pkg::xy_type'{x: s0_ff.center_x, y: s0_ff.center_y}
                           : cand_right_ff;

   assign sum_valid       = s0_valid_ff && s0_ff.frame_end;
   assign sum.left_x      = left_found_nx  ? cand_left_nx.x  : track_left_ff.x;
   assign sum.right_x     = right_found_nx ? cand_right_nx.x : track_right_ff.x;
   assign sum.left_found  = left_found_nx;
   assign sum.right_found = right_found_nx;

   always_comb begin
      left_found_in  = left_found_ff;
      right_found_in = right_found_ff;
      best_left_in   = best_left_ff;
      best_right_in  = best_right_ff;
      cand_left_in   = cand_left_ff;
      cand_right_in  = cand_right_ff;
      track_left_in  = track_left_ff;
      track_right_in = track_right_ff;
      if (s0_go) begin
         if (s0_ff.frame_end) begin
            left_found_in  = 1'b0;
            right_found_in = 1'b0;
            track_left_in  = left_found_nx  ? cand_left_nx  : track_left_ff;
            track_right_in = right_found_nx ? cand_right_nx : track_right_ff;
         end else begin
            left_found_in  = left_found_nx;
            right_found_in = right_found_nx;
            cand_left_in   = cand_left_nx;
            cand_right_in  = cand_right_nx;
            best_left_in   = hit_left  ? dist_left  : best_left_ff;
            best_right_in  = hit_right ? dist_right : best_right_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff    <= 1'b0;
         left_found_ff  <= 1'b0;
         right_found_ff <= 1'b0;
         track_left_ff  <= lbts_pkg::TRACK_LEFT_RESET;
         track_right_ff <= lbts_pkg::TRACK_RIGHT_RESET;
      end else begin
         s0_valid_ff    <= s0_valid_in;
         left_found_ff  <= left_found_in;
         right_found_ff <= right_found_in;
         track_left_ff  <= track_left_in;
         track_right_ff <= track_right_in;
      end
   end

   always_ff @(posedge clock) begin
      s0_ff         <= s0_in;
      best_left_ff  <= best_left_in;
      best_right_ff <= best_right_in;
      cand_left_ff  <= cand_left_in;
      cand_right_ff <= cand_right_in;
   end

   `ASSERT_NEXT(a_frame_end_clears, clock, reset, s0_go && s0_ff.frame_end, !left_found_ff && !right_found_ff)
   `ASSERT_NEXT(a_track_holds, clock, reset, !(s0_go && s0_ff.frame_end), $stable(track_left_ff) && $stable(track_right_ff))
   `ASSERT_IMPLIES(a_one_side, clock, reset, s0_valid_ff, !(hit_left && hit_right))
   `ASSERT_IMPLIES(a_found_source, clock, reset, $rose(left_found_ff) || $rose(right_found_ff), $past(s0_go))

endmodule

[hw/rtl/lbts_steer.sv]
`include "assert_macros.svh"

module lbts_steer (
   input  logic              clock,
   input  logic              reset,
   input  lbts_pkg::cfg_type cfg,
   input  logic              sum_valid,
   output logic              sum_ready,
   input  lbts_pkg::sum_type sum,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lbts_pkg::rsp_type rsp
);

   logic                                p1_valid_ff, p1_valid_in;
   lbts_pkg::sum_type                   p1_ff, p1_in;
   logic                                p2_valid_ff, p2_valid_in;
   lbts_pkg::sum_type                   p2_ff, p2_in;
   logic signed [lbts_pkg::ERR_W-1:0]   p2_err_ff, p2_err_in;
   logic                                p3_valid_ff, p3_valid_in;
   lbts_pkg::sum_type                   p3_ff, p3_in;
   logic signed [lbts_pkg::ERR_W-1:0]   p3_err_ff, p3_err_in;
   logic signed [lbts_pkg::PROD_W-1:0]  p3_prod_ff, p3_prod_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   lbts_pkg::rsp_type                   out_ff, out_in;

   logic                                out_ready, p3_ready, p2_ready, p1_ready;
   logic [lbts_pkg::MID_W-1:0]          mid;
   logic [lbts_pkg::MID_W:0]            mid_x2;
   logic [lbts_pkg::POS_W:0]            pos_sum;
   logic signed [lbts_pkg::ERRX_W-1:0]  err_wide;
   logic [lbts_pkg::ERRX_W-lbts_pkg::ERR_W:0] err_top;
   logic signed [lbts_pkg::ERR_W-1:0]   err_sat;
   logic signed [lbts_pkg::PROD_W:0]    rnd;
   logic signed [lbts_pkg::Q_W-1:0]     q;
   logic signed [lbts_pkg::BASEX_W-1:0] base_x16;
   logic signed [lbts_pkg::SPDX_W-1:0]  left_wide, right_wide;

   function automatic logic signed [lbts_pkg::SPEED_W-1:0] sat_speed(
      input logic signed [lbts_pkg::SPDX_W-1:0] v
   );
      logic [lbts_pkg::SPDX_W-lbts_pkg::SPEED_W:0] top;
      logic signed [lbts_pkg::SPEED_W-1:0]          r;
      top = v[lbts_pkg::SPDX_W-1:lbts_pkg::SPEED_W-1];
      if (top == '0 || top == '1) begin
         r = v[lbts_pkg::SPEED_W-1:0];
      end else if (v[lbts_pkg::SPDX_W-1]) begin
         r = {1'b1, {(lbts_pkg::SPEED_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(lbts_pkg::SPEED_W-1){1'b1}}};
      end
      return r;
   endfunction

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign p3_ready  = !p3_valid_ff || out_ready;
   assign p2_ready  = !p2_valid_ff || p3_ready;
   assign p1_ready  = !p1_valid_ff || p2_ready;
   assign sum_ready = p1_ready;

   // Error: twice the midline minus the sum of the lane positions, 1/32 pixel.
   assign mid      = lbts_pkg::mid_of(cfg.frame_width);
   assign mid_x2   = {mid, 1'b0};
   assign pos_sum  = {1'b0, p1_ff.left_x} + {1'b0, p1_ff.right_x};
   assign err_wide = $signed(lbts_pkg::ERRX_W'(mid_x2)) - $signed(lbts_pkg::ERRX_W'(pos_sum));
   assign err_top  = err_wide[lbts_pkg::ERRX_W-1:lbts_pkg::ERR_W-1];

   always_comb begin
      if (err_top == '0 || err_top == '1) begin
         err_sat = err_wide[lbts_pkg::ERR_W-1:0];
      end else if (err_wide[lbts_pkg::ERRX_W-1]) begin
         err_sat = {1'b1, {(lbts_pkg::ERR_W-1){1'b0}}};
      end else begin
         err_sat = {1'b0, {(lbts_pkg::ERR_W-1){1'b1}}};
      end
   end

   // Rounded correction: floor((err * gain + 256) / 512).
   assign rnd = $signed({p3_prod_ff[lbts_pkg::PROD_W-1], p3_prod_ff}) +
                $signed((lbts_pkg::PROD_W + 1)'(lbts_pkg::ROUND_HALF));
   assign q   = rnd[lbts_pkg::PROD_W:lbts_pkg::ROUND_SHIFT];

   assign base_x16   = {cfg.base_speed, {lbts_pkg::BASE_SHIFT{1'b0}}};
   assign left_wide  = lbts_pkg::SPDX_W'(base_x16) - lbts_pkg::SPDX_W'(q);
   assign right_wide = -(lbts_pkg::SPDX_W'(base_x16) + lbts_pkg::SPDX_W'(q));

   always_comb begin
      p1_valid_in  = p1_ready ? sum_valid : p1_valid_ff;
      p1_in        = (sum_valid && p1_ready) ? sum : p1_ff;

      p2_valid_in  = p2_ready ? p1_valid_ff : p2_valid_ff;
      p2_in        = (p1_valid_ff && p2_ready) ? p1_ff : p2_ff;
      p2_err_in    = (p1_valid_ff && p2_ready) ? err_sat : p2_err_ff;

      p3_valid_in  = p3_ready ? p2_valid_ff : p3_valid_ff;
      p3_in        = (p2_valid_ff && p3_ready) ? p2_ff : p3_ff;
      p3_err_in    = (p2_valid_ff && p3_ready) ? p2_err_ff : p3_err_ff;
      p3_prod_in   = (p2_valid_ff && p3_ready)
                     ? $signed(p2_err_ff) * $signed({1'b0, cfg.steer_gain})
                     : p3_prod_ff;

      rsp_valid_in = out_ready ? p3_valid_ff : rsp_valid_ff;
      out_in       = out_ff;
      if (p3_valid_ff && out_ready) begin
         out_in.steer_error = p3_err_ff;
         out_in.left_pos    = p3_ff.left_x;
         out_in.right_pos   = p3_ff.right_x;
         out_in.left_found  = p3_ff.left_found;
         out_in.right_found = p3_ff.right_found;
         if (cfg.drive_enable) begin
            out_in.left_speed  = sat_speed(left_wide);
            out_in.right_speed = sat_speed(right_wide);
         end else begin
            out_in.left_speed  = '0;
            out_in.right_speed = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff  <= p1_valid_in;
         p2_valid_ff  <= p2_valid_in;
         p3_valid_ff  <= p3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff      <= p1_in;
      p2_ff      <= p2_in;
      p2_err_ff  <= p2_err_in;
      p3_ff      <= p3_in;
      p3_err_ff  <= p3_err_in;
      p3_prod_ff <= p3_prod_in;
      out_ff     <= out_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = out_ff;

   `ASSERT_IMPLIES(a_disabled_zero, clock, reset, rsp_valid_ff && !cfg.drive_enable, out_ff.left_speed == '0 && out_ff.right_speed == '0)
   `ASSERT_NEXT(a_p3_moves, clock, reset, p3_valid_ff && out_ready, rsp_valid_ff)
   `ASSERT_NEXT(a_sum_taken, clock, reset, sum_valid && sum_ready, p1_valid_ff)

endmodule

[hw/rtl/lane_blob_tracker_steer_top.sv]
// Lane blob tracker with steering output. Each item is one blob record or a bare
// frame end; blobs below min_area are dropped, the rest are sorted left or right
// of the midline and the nearest one within the gate to each tracked lane is kept.
// An item with frame_end set closes the frame and yields exactly one result with
// the steering error, the two wheel speeds, the updated lane positions and the
// found flags; other items yield nothing. One item is accepted every cycle unless
// req_stall holds a frame-end item. The limit is the per-item update of each side's
// running best distance, done combinationally between the input register and the
// tracker state. A result passes the input, lane summary, error, gain multiply and
// speed saturation registers. The user writes configuration via the csr port only
// while no item is in flight; the block doesn't enforce it. csr_ready is always high.
module lane_blob_tracker_steer_top (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_has_blob,
   input  logic [lbts_pkg::AREA_W-1:0]          req_blob_area,
   input  logic [lbts_pkg::POS_W-1:0]           req_center_x,
   input  logic [lbts_pkg::POS_W-1:0]           req_center_y,
   input  logic                                 req_frame_end,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [lbts_pkg::SPEED_W-1:0]  rsp_left_speed,
   output logic signed [lbts_pkg::SPEED_W-1:0]  rsp_right_speed,
   output logic signed [lbts_pkg::ERR_W-1:0]    rsp_steer_error,
   output logic [lbts_pkg::POS_W-1:0]           rsp_left_pos,
   output logic [lbts_pkg::POS_W-1:0]           rsp_right_pos,
   output logic                                 rsp_left_found,
   output logic                                 rsp_right_found,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lbts_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lbts_pkg::CSR_DATA_W-1:0]      csr_data
);

   lbts_pkg::cfg_type cfg_ff, cfg_in;
   lbts_pkg::req_type req;
   lbts_pkg::sum_type sum;
   lbts_pkg::rsp_type rsp;
   logic              sum_valid;
   logic              sum_ready;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (lbts_pkg::csr_index_type'(csr_index))
            lbts_pkg::REG_MIN_AREA: begin
               cfg_in.min_area = csr_data[lbts_pkg::AREA_W-1:0];
            end
            lbts_pkg::REG_LEFT_GATE: begin
               cfg_in.left_gate = csr_data[lbts_pkg::POS_W-1:0];
            end
            lbts_pkg::REG_RIGHT_GATE: begin
               cfg_in.right_gate = csr_data[lbts_pkg::POS_W-1:0];
            end
            lbts_pkg::REG_FRAME_WIDTH: begin
               cfg_in.frame_width = csr_data[lbts_pkg::FW_W-1:0];
            end
            lbts_pkg::REG_STEER_GAIN: begin
               cfg_in.steer_gain = csr_data[lbts_pkg::GAIN_W-1:0];
            end
            lbts_pkg::REG_BASE_SPEED: begin
               cfg_in.base_speed = $signed(csr_data[lbts_pkg::BASE_W-1:0]);
            end
            lbts_pkg::REG_DRIVE_ENABLE: begin
               cfg_in.drive_enable = csr_data[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= lbts_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req.has_blob  = req_has_blob;
   assign req.blob_area = req_blob_area;
   assign req.center_x  = req_center_x;
   assign req.center_y  = req_center_y;
   assign req.frame_end = req_frame_end;

   lbts_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .sum_valid (sum_valid),
      .sum_ready (sum_ready),
      .sum       (sum)
   );

   lbts_steer u_steer (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .sum_valid (sum_valid),
      .sum_ready (sum_ready),
      .sum       (sum),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_left_speed  = rsp.left_speed;
   assign rsp_right_speed = rsp.right_speed;
   assign rsp_steer_error = rsp.steer_error;
   assign rsp_left_pos    = rsp.left_pos;
   assign rsp_right_pos   = rsp.right_pos;
   assign rsp_left_found  = rsp.left_found;
   assign rsp_right_found = rsp.right_found;

endmodule

[sim/lane_blob_tracker_steer_top_tb.sv]
`timescale 1ns / 1ps

module lane_blob_tracker_steer_top_tb;
   import lbts_pkg::*;

   typedef struct {
      logic [POS_W-1:0] lx;
      logic [POS_W-1:0] ly;
      logic [POS_W-1:0] rx;
      logic [POS_W-1:0] ry;
      longint           best_l;
      longint           best_r;
      xy_type           cand_l;
      xy_type           cand_r;
      bit               found_l;
      bit               found_r;
   } lane_state_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_has_blob = 1'b0;
   logic [AREA_W-1:0]     req_blob_area = '0;
   logic [POS_W-1:0]      req_center_x = '0;
   logic [POS_W-1:0]      req_center_y = '0;
   logic                  req_frame_end = 1'b0;

   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic signed [SPEED_W-1:0] rsp_left_speed;
   logic signed [SPEED_W-1:0] rsp_right_speed;
   logic signed [ERR_W-1:0]   rsp_steer_error;
   logic [POS_W-1:0]      rsp_left_pos;
   logic [POS_W-1:0]      rsp_right_pos;
   logic                  rsp_left_found;
   logic                  rsp_right_found;

   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Register copy and lane state as the block should hold them; plan_lanes runs ahead
   // at fill time so that random blobs can be aimed at the tracked lanes.
   cfg_type        cfg_now;
   lane_state_type lanes;
   lane_state_type plan_lanes;
   req_type        pending_items[$];
   rsp_type        expected_frames[$];

   int fail_count = 0;
   int gap_left = 0;
   int stall_left = 0;
   bit req_taken = 1'b0;
   bit csr_taken = 1'b0;
   bit settled = 1'b0;
   bit calm = 1'b0;

   lane_blob_tracker_steer_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_has_blob    (req_has_blob),
      .req_blob_area   (req_blob_area),
      .req_center_x    (req_center_x),
      .req_center_y    (req_center_y),
      .req_frame_end   (req_frame_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_left_speed  (rsp_left_speed),
      .rsp_right_speed (rsp_right_speed),
      .rsp_steer_error (rsp_steer_error),
      .rsp_left_pos    (rsp_left_pos),
      .rsp_right_pos   (rsp_right_pos),
      .rsp_left_found  (rsp_left_found),
      .rsp_right_found (rsp_right_found),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint clamp_signed(input longint v, input int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) << (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         return hi;
      end
      return (v < lo) ? lo : v;
   endfunction

   function automatic longint mid_fixed(input cfg_type c);
      return (c.frame_width > MAX_WIDTH) ? longint'(MAX_WIDTH) * 8 : longint'(c.frame_width) * 8;
   endfunction

   function automatic longint sq_dist(input longint ax, input longint ay,
                                      input longint bx, input longint by);
      return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
   endfunction

   function automatic int clamp_pos(input int v);
      if (v < 0) begin
         return 0;
      end
      return (v > 16383) ? 16383 : v;
   endfunction

   // Applies one item to the lane state; returns 1 with the frame summary when the
   // item closes a frame.
   function automatic bit track_item(inout lane_state_type s, input cfg_type c,
                                     input req_type it, output rsp_type r);
      longint mid;
      longint mid2;
      longint d;
      longint err;
      longint q;
      longint b;
      mid = mid_fixed(c);
      mid2 = mid * mid;
      r = '0;
      if (it.has_blob && it.blob_area >= c.min_area) begin
         if (longint'(it.center_x) < mid) begin
            d = sq_dist(it.center_x, it.center_y, s.lx, s.ly);
            if (d < (s.found_l ? s.best_l : mid2) &&
                d <= longint'(c.left_gate) * longint'(c.left_gate)) begin
               s.best_l = d;
               s.cand_l = '{x: it.center_x, y: it.center_y};
               s.found_l = 1'b1;
            end
         end else begin
            d = sq_dist(it.center_x, it.center_y, s.rx, s.ry);
            if (d < (s.found_r ? s.best_r : mid2) &&
                d <= longint'(c.right_gate) * longint'(c.right_gate)) begin
               s.best_r = d;
               s.cand_r = '{x: it.center_x, y: it.center_y};
               s.found_r = 1'b1;
            end
         end
      end
      if (!it.frame_end) begin
         return 1'b0;
      end
      if (s.found_l) begin
         s.lx = s.cand_l.x;
         s.ly = s.cand_l.y;
      end
      if (s.found_r) begin
         s.rx = s.cand_r.x;
         s.ry = s.cand_r.y;
      end
      err = clamp_signed(2 * mid - (longint'(s.lx) + longint'(s.rx)), ERR_W);
      if (c.drive_enable) begin
         // Round to nearest with ties upward: add half, then floor.
         q = (err * longint'(c.steer_gain) + 256) >>> 9;
         b = longint'(c.base_speed) * 16;
         r.left_speed = SPEED_W'(clamp_signed(b - q, SPEED_W));
         r.right_speed = SPEED_W'(clamp_signed(-(b + q), SPEED_W));
      end
      r.steer_error = ERR_W'(err);
      r.left_pos = s.lx;
      r.right_pos = s.rx;
      r.left_found = s.found_l;
      r.right_found = s.found_r;
      s.found_l = 1'b0;
      s.found_r = 1'b0;
      s.cand_l = '0;
      s.cand_r = '0;
      s.best_l = mid2;
      s.best_r = mid2;
      return 1'b1;
   endfunction

   function automatic void check_field(input string name, input longint want_v,
                                       input longint got_v);
      if (want_v != got_v) begin
         $error("%s: expected %0d, actual %0d", name, want_v, got_v);
         fail_count++;
      end
   endfunction

   task automatic push_item(input bit has, input int area, input int cx, input int cy,
                            input bit fend);
      req_type it;
      rsp_type ignored;
      it.has_blob = has;
      it.blob_area = AREA_W'(area);
      it.center_x = POS_W'(cx);
      it.center_y = POS_W'(cy);
      it.frame_end = fend;
      pending_items.push_back(it);
      void'(track_item(plan_lanes, cfg_now, it, ignored));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (!settled) begin
         @(negedge clock);
      end
      // Items without a result may still be in the pipeline.
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input int value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= CSR_DATA_W'(value);
      csr_taken = 1'b0;
      do begin
         @(negedge clock);
      end while (!csr_taken);
      csr_valid <= 1'b0;
   endtask

   // Frames of zero to five blobs, mostly aimed near the tracked lanes, each closed
   // either on its last blob or by a bare frame end.
   task automatic run_phase(input int n_items);
      int counted;
      int n_blobs;
      int g;
      int span;
      int cx;
      int cy;
      int area;
      int pick;
      bit side;
      bit fend_on_blob;
      counted = 0;
      while (counted < n_items) begin
         n_blobs = $urandom_range(0, 5);
         fend_on_blob = (n_blobs > 0) && ($urandom_range(0, 1) == 1);
         for (int i = 0; i < n_blobs; i++) begin
            if ($urandom_range(0, 7) == 0) begin
               push_item(1'b0, $urandom, $urandom, $urandom, 1'b0);
            end
            side = $urandom_range(0, 1);
            if ($urandom_range(0, 9) < 8) begin
               g = side ? int'(cfg_now.right_gate) : int'(cfg_now.left_gate);
               span = g + g / 8 + 2;
               cx = clamp_pos((side ? int'(plan_lanes.rx) : int'(plan_lanes.lx))
                              + int'($urandom_range(0, 2 * span)) - span);
               cy = clamp_pos((side ? int'(plan_lanes.ry) : int'(plan_lanes.ly))
                              + int'($urandom_range(0, span)) - span / 2);
            end else begin
               cx = $urandom_range(0, 16383);
               cy = $urandom_range(0, 16383);
            end
            pick = $urandom_range(0, 9);
            if (pick == 0 && cfg_now.min_area > 0) begin
               area = $urandom_range(0, int'(cfg_now.min_area) - 1);
            end else if (pick == 1) begin
               area = cfg_now.min_area;
            end else begin
               area = $urandom_range(int'(cfg_now.min_area), 262143);
            end
            push_item(1'b1, area, cx, cy, fend_on_blob && (i == n_blobs - 1));
            counted++;
         end
         if (!fend_on_blob) begin
            push_item(1'b0, $urandom, $urandom, $urandom, 1'b1);
            counted++;
         end
      end
      wait_drained();
   endtask

   always @(negedge clock) begin : driver
      req_type it;
      if (!reset && (!req_valid || req_taken)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            it = pending_items.pop_front();
            req_valid <= 1'b1;
            req_has_blob <= it.has_blob;
            req_blob_area <= it.blob_area;
            req_center_x <= it.center_x;
            req_center_y <= it.center_y;
            req_frame_end <= it.frame_end;
            if (!calm && $urandom_range(0, 3) == 0) begin
               gap_left = $urandom_range(1, 3);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : stall_driver
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if (!calm && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 3);
         end
      end
   end

   always @(posedge clock) begin : monitor
      rsp_type want;
      req_type seen;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               REG_MIN_AREA:     cfg_now.min_area = csr_data[AREA_W-1:0];
               REG_LEFT_GATE:    cfg_now.left_gate = csr_data[POS_W-1:0];
               REG_RIGHT_GATE:   cfg_now.right_gate = csr_data[POS_W-1:0];
               REG_FRAME_WIDTH:  cfg_now.frame_width = csr_data[FW_W-1:0];
               REG_STEER_GAIN:   cfg_now.steer_gain = csr_data[GAIN_W-1:0];
               REG_BASE_SPEED:   cfg_now.base_speed = csr_data[BASE_W-1:0];
               REG_DRIVE_ENABLE: cfg_now.drive_enable = csr_data[0];
               default: ;
            endcase
            csr_taken = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_frames.size() == 0) begin
               $error("result arrived with no frame summary pending");
               fail_count++;
            end else begin
               want = expected_frames.pop_front();
               check_field("left_speed", want.left_speed, rsp_left_speed);
               check_field("right_speed", want.right_speed, rsp_right_speed);
               check_field("steer_error", want.steer_error, rsp_steer_error);
               check_field("left_pos", want.left_pos, rsp_left_pos);
               check_field("right_pos", want.right_pos, rsp_right_pos);
               check_field("left_found", want.left_found, rsp_left_found);
               check_field("right_found", want.right_found, rsp_right_found);
            end
         end
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            seen.has_blob = req_has_blob;
            seen.blob_area = req_blob_area;
            seen.center_x = req_center_x;
            seen.center_y = req_center_y;
            seen.frame_end = req_frame_end;
            if (track_item(lanes, cfg_now, seen, want)) begin
               expected_frames.push_back(want);
            end
         end
         settled = (pending_items.size() == 0) && !req_valid && !req_taken &&
                   (expected_frames.size() == 0);
      end
   end

   initial begin : main
      cfg_now = CFG_RESET;
      lanes.lx = TRACK_LEFT_RESET.x;
      lanes.ly = TRACK_LEFT_RESET.y;
      lanes.rx = TRACK_RIGHT_RESET.x;
      lanes.ry = TRACK_RIGHT_RESET.y;
      lanes.best_l = mid_fixed(CFG_RESET) * mid_fixed(CFG_RESET);
      lanes.best_r = lanes.best_l;
      lanes.cand_l = '0;
      lanes.cand_r = '0;
      lanes.found_l = 1'b0;
      lanes.found_r = 1'b0;
      plan_lanes = lanes;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings, wheels off.
      push_item(1'b0, 262143, 16383, 16383, 1'b0);  // blob fields without a blob
      push_item(1'b0, 0, 0, 0, 1'b1);               // empty frame
      push_item(1'b1, 299, 2400, 720, 1'b1);        // one pixel under min_area
      push_item(1'b1, 300, 2400, 720, 1'b0);        // exactly on the left track
      push_item(1'b1, 262143, 8643, 724, 1'b0);
      push_item(1'b1, 262143, 8636, 723, 1'b0);     // same distance, first one stays
      push_item(1'b0, 0, 0, 0, 1'b1);
      push_item(1'b1, 1000, 1119, 720, 1'b1);       // one step beyond the left gate
      push_item(1'b1, 1000, 1120, 720, 1'b1);       // exactly on the left gate
      push_item(1'b1, 1000, 5120, 724, 1'b0);       // on the midline goes right
      push_item(1'b1, 1000, 5119, 720, 1'b1);
      push_item(1'b1, 262143, 16383, 16383, 1'b1);
      push_item(1'b1, 0, 0, 0, 1'b1);
      wait_drained();

      write_reg(REG_DRIVE_ENABLE, 1);
      run_phase(90);

      write_reg(REG_MIN_AREA, 0);
      write_reg(REG_LEFT_GATE, 16383);
      write_reg(REG_RIGHT_GATE, 16383);
      write_reg(REG_FRAME_WIDTH, 1024);
      write_reg(REG_STEER_GAIN, 65535);
      write_reg(REG_BASE_SPEED, 16'h8000);
      push_item(1'b1, 0, 8192, 0, 1'b0);
      push_item(1'b1, 0, 8191, 0, 1'b1);
      run_phase(80);

      // Zero width: every blob lands right and none can be accepted.
      write_reg(REG_FRAME_WIDTH, 0);
      write_reg(REG_STEER_GAIN, 0);
      write_reg(REG_BASE_SPEED, 32767);
      run_phase(20);

      // Oversized width is clamped; zero gates accept only exact hits.
      write_reg(REG_FRAME_WIDTH, 2047);
      write_reg(REG_MIN_AREA, 262143);
      write_reg(REG_LEFT_GATE, 0);
      write_reg(REG_RIGHT_GATE, 0);
      run_phase(30);

      write_reg(REG_FRAME_WIDTH, 1);
      write_reg(REG_MIN_AREA, 300);
      write_reg(REG_LEFT_GATE, 800);
      write_reg(REG_RIGHT_GATE, 3000);
      write_reg(REG_STEER_GAIN, 36);
      write_reg(REG_BASE_SPEED, 100);
      run_phase(40);

      for (int p = 0; p < 4; p++) begin
         write_reg(REG_MIN_AREA, $urandom_range(0, 2000));
         write_reg(REG_LEFT_GATE, $urandom_range(100, 4000));
         write_reg(REG_RIGHT_GATE, $urandom_range(100, 4000));
         write_reg(REG_FRAME_WIDTH, $urandom_range(64, 1100));
         write_reg(REG_STEER_GAIN, $urandom_range(0, 65535));
         write_reg(REG_BASE_SPEED, $urandom_range(0, 65535));
         write_reg(REG_DRIVE_ENABLE, $urandom_range(0, 1));
         if (p == 3) begin
            calm = 1'b1;
         end
         run_phase(65);
      end

      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin : watchdog
      #3_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/lbts_pkg.sv
hw/rtl/lbts_tracker.sv
hw/rtl/lbts_steer.sv
hw/rtl/lane_blob_tracker_steer_top.sv
sim/lane_blob_tracker_steer_top_tb.sv
